// ===== rtl/trdq_pkg.sv =====
// Package: widths, status codes, register indexes, and entry, command and result types.
`default_nettype none
package trdq_pkg;
	localparam int TimeW = 48;
	localparam int TagW = 16;
	localparam int WinW = 32;
	localparam int LimW = 8;
	localparam int CfgW = 48;
	localparam int CfgIdxW = 2;
	localparam int DefDepth = 16;
	localparam int CountW = 5;

	localparam logic [2:0] ST_PUSHED   = 3'd0;
	localparam logic [2:0] ST_BAD_TIME = 3'd1;
	localparam logic [2:0] ST_SHUTDOWN = 3'd2;
	localparam logic [2:0] ST_TOO_OLD  = 3'd3;
	localparam logic [2:0] ST_OLD_RST  = 3'd4;
	localparam logic [2:0] ST_FULL     = 3'd5;
	localparam logic [2:0] ST_PULLED   = 3'd6;
	localparam logic [2:0] ST_NOT_RDY  = 3'd7;

	localparam logic [CfgIdxW-1:0] REG_WINDOW = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_MIN    = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_MAX    = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_LIMIT  = 2'd3;

	typedef struct packed {
		logic [TimeW-1:0] t;
		logic             quit;
		logic [TagW-1:0]  tag;
	} entry_t;

	// Per-cell command from the controller
	typedef struct packed {
		logic push;
		logic pull;
		logic clear;
	} cell_cmd_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [TimeW-1:0]  out_time;
		logic [TagW-1:0]   out_tag;
		logic              out_is_quit;
		logic              ready_res;
		logic [CountW-1:0] event_count;
		logic              shutting_down;
		logic              initialized;
	} result_t;
endpackage
`default_nettype wire

// ===== rtl/trdq_if.sv =====
// Valid/ready channel interface with generic payload.
`default_nettype none
interface trdq_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/trdq_cell.sv =====
// One sorted cell: holds an entry, shifts up on insert, down on pull.
`default_nettype none
module trdq_cell import trdq_pkg::*; (
	input  wire             clk,
	input  wire             arst_n,
	input  wire cell_cmd_t  cmd,
	input  wire [TimeW-1:0] new_time,
	input  wire             head_ins,
	input  wire entry_t     new_entry,
	input  wire             occ_prev,
	input  wire entry_t     prev_entry,
	input  wire             gt_prev,
	input  wire entry_t     next_entry,
	input  wire             occ_next,
	output logic            occ,
	output logic            gt,
	output entry_t          entry
);
	logic   occ_q;
	entry_t entry_q;

	// Entry is later than the new time, or the new event goes at the head: it moves up
	assign gt = occ_q && ((entry_q.t > new_time) || head_ins);
	assign occ = occ_q;
	assign entry = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (cmd.push) begin
			if (gt || (!occ_q && occ_prev)) begin
				occ_q <= 1'b1;
			end
		end else if (cmd.pull) begin
			occ_q <= occ_next;
		end else if (cmd.clear) begin
			occ_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			if (gt || !occ_q) begin
				entry_q <= gt_prev ? prev_entry : new_entry;
			end
		end else if (cmd.pull) begin
			entry_q <= next_entry;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/timestamp_reorder_delay_queue.sv =====
// Timestamp reorder delay queue: a chain of sorted cells with a controller.
// Latency: the result is registered on the request transfer and is valid in the cycle after it.
// Throughput: one request per cycle; the cell chain inserts or pops on the transfer itself.
// A new request is taken while the result waits only if the result register frees.
// Reset: arst_n clears the queue, flags and registers to their defaults.
// The cell contents and result data carry no reset; occupancy bits mark valid entries.
`default_nettype none
module timestamp_reorder_delay_queue import trdq_pkg::*; #(
	parameter int QUEUE_DEPTH = DefDepth
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  wire [CfgIdxW+1:0]   cfg_index,
	input  wire [CfgW-1:0]      cfg_data,
	trdq_if.sink                req,
	trdq_if.source              res
);
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	logic [WinW-1:0]  win_q;
	logic [TimeW-1:0] min_q, max_q, oldest_q, newest_q;
	logic [LimW-1:0]  limit_q, bad_q;
	logic             init_q, quit_q, res_valid_q;
	logic [CntW-1:0]  cnt_q;
	result_t          res_q;

	logic             req_type, is_quit;
	logic [TimeW-1:0] ev_time;
	logic [TagW-1:0]  ev_tag;
	assign req_type = req.data.req_type;
	assign is_quit  = req.data.is_quit;
	assign ev_time  = req.data.event_time;
	assign ev_tag   = req.data.event_tag;

	logic   occ [QUEUE_DEPTH+1];
	logic   gt [QUEUE_DEPTH+1];
	entry_t ents [QUEUE_DEPTH+1];
	entry_t new_entry;
	cell_cmd_t cmd;
	logic   head_ins;
	assign new_entry = '{t: ev_time, quit: is_quit, tag: ev_tag};
	assign occ[QUEUE_DEPTH] = 1'b0;
	assign gt[QUEUE_DEPTH] = 1'b0;
	assign ents[QUEUE_DEPTH] = new_entry;

	// Tail later than the new time and head equal to it: the new event goes first
	assign head_ins = (cnt_q != '0) && (newest_q > ev_time) && (ents[0].t == ev_time);

	// Cell chain
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		trdq_cell u_cell (
			.clk, .arst_n, .cmd,
			.new_time(ev_time), .head_ins, .new_entry,
			.occ_prev(i == 0 ? 1'b1 : occ[i == 0 ? 0 : i-1]),
			.prev_entry(ents[i == 0 ? 0 : i-1]),
			.gt_prev(i == 0 ? 1'b0 : gt[i == 0 ? 0 : i-1]),
			.next_entry(ents[i+1]), .occ_next(occ[i+1]),
			.occ(occ[i]), .gt(gt[i]), .entry(ents[i])
		);
	end

	// Decision logic
	logic take, clear, waits;
	logic [2:0] st;
	logic [TimeW-1:0] nt_head, nt_tail;
	logic [CntW-1:0] cnt_d;
	logic [LimW:0] bad_inc;
	assign take = req.valid && req.ready;
	assign req.ready = !res_valid_q || res.ready;
	assign waits = init_q && !quit_q && ((newest_q - oldest_q) < TimeW'(win_q));
	assign bad_inc = {1'b0, bad_q} + 1'b1;

	always_comb begin
		cmd = '0;
		clear = 1'b0;
		if (req_type == 1'b0) begin
			if (ev_time < min_q || ev_time > max_q) st = ST_BAD_TIME;
			else if (quit_q) st = ST_SHUTDOWN;
			else if (init_q && !is_quit && newest_q > ev_time &&
					(newest_q - ev_time) > TimeW'(win_q)) begin
				if (bad_inc > {1'b0, limit_q}) begin
					st = ST_OLD_RST;
					clear = 1'b1;
					cmd.clear = take;
				end else st = ST_TOO_OLD;
			end else if (cnt_q == CntW'(QUEUE_DEPTH)) st = ST_FULL;
			else begin
				st = ST_PUSHED;
				cmd.push = take;
			end
		end else begin
			if (!init_q || cnt_q == '0 || waits) st = ST_NOT_RDY;
			else begin
				st = ST_PULLED;
				cmd.pull = take;
			end
		end
	end

	// Post-push head/tail: new event is head if every held cell moves up
	always_comb begin
		nt_head = (cnt_q == '0 || gt[0]) ? ev_time : ents[0].t;
		nt_tail = (cnt_q == '0 || newest_q <= ev_time) ? ev_time : newest_q;
	end

	// Control state
	logic [CntW-1:0] cnt_n;
	logic init_n, quit_n, rdy_n;
	logic [TimeW-1:0] old_n, new_n;
	always_comb begin
		cnt_n = cnt_q; init_n = init_q; quit_n = quit_q;
		old_n = oldest_q; new_n = newest_q;
		if (clear) begin
			cnt_n = '0; init_n = 1'b0; quit_n = 1'b0; old_n = '0; new_n = '0;
		end else if (st == ST_PUSHED) begin
			cnt_n = cnt_q + 1'b1; init_n = 1'b1; quit_n = quit_q | is_quit;
			old_n = nt_head; new_n = nt_tail;
		end else if (st == ST_PULLED) begin
			cnt_n = cnt_q - 1'b1;
			if (cnt_q > CntW'(1)) old_n = ents[1].t;
		end
		rdy_n = (cnt_n != '0) &&
			!(init_n && !quit_n && ((new_n - old_n) < TimeW'(win_q)));
	end
	assign cnt_d = cnt_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0; min_q <= '0; max_q <= '1; limit_q <= LimW'(10);
			cnt_q <= '0; bad_q <= '0; init_q <= 1'b0; quit_q <= 1'b0;
			oldest_q <= '0; newest_q <= '0; res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					{2'b00, REG_WINDOW}: win_q <= cfg_data[WinW-1:0];
					{2'b00, REG_MIN}:    min_q <= cfg_data[TimeW-1:0];
					{2'b00, REG_MAX}:    max_q <= cfg_data[TimeW-1:0];
					{2'b00, REG_LIMIT}:  limit_q <= cfg_data[LimW-1:0];
					default: ;
				endcase
			end
			if (res.ready) res_valid_q <= 1'b0;
			if (take) begin
				res_valid_q <= 1'b1;
				cnt_q <= cnt_d; init_q <= init_n; quit_q <= quit_n;
				oldest_q <= old_n; newest_q <= new_n;
				if (clear || st == ST_PUSHED) bad_q <= '0;
				else if (st == ST_TOO_OLD) bad_q <= bad_inc[LimW-1:0];
			end
		end
	end

	// A queue reset drops the occupancy bit of every cell along with the count.

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.status <= st;
			res_q.out_time <= (st == ST_PULLED) ? ents[0].t : '0;
			res_q.out_tag <= (st == ST_PULLED) ? ents[0].tag : '0;
			res_q.out_is_quit <= (st == ST_PULLED) ? ents[0].quit : 1'b0;
			res_q.ready_res <= rdy_n;
			res_q.event_count <= CountW'(cnt_n);
			res_q.shutting_down <= quit_n;
			res_q.initialized <= init_n;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data.status = res_q.status;
	assign res.data.out_time = res_q.out_time;
	assign res.data.out_tag = res_q.out_tag;
	assign res.data.out_is_quit = res_q.out_is_quit;
	assign res.data.ready_res = res_q.ready_res;
	assign res.data.event_count = res_q.event_count;
	assign res.data.shutting_down = res_q.shutting_down;
	assign res.data.initialized = res_q.initialized;
endmodule
`default_nettype wire
